>>> hw/rtl/scr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Second-chance replacement package
// Shared types for the slot cells, the scan controller and the top level.
// ----------------------------------------------------------------------------
package scr_pkg;

  // Controller states: idle, search for a hit, clock-hand victim search.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HIT,
    ST_CLOCK
  } state_t;

  // Broadcast from the controller to every slot cell.
  typedef struct packed {
    logic run;         // a scan token may move this cycle
    logic clock_mode;  // victim search instead of hit search
  } scan_t;

  // Summary of the cell row seen by the controller.
  typedef struct packed {
    logic stop;        // the token stopped on its cell this cycle
    logic ev_valid;    // the stopping cell held a valid page
  } status_t;

endpackage : scr_pkg
`default_nettype wire

>>> hw/rtl/scr_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot cell
// Holds one frame slot and passes the scan token to its neighbor.
// ----------------------------------------------------------------------------
module scr_cell #(
  parameter int PAGE_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  scr_pkg::scan_t       scan,
  input  wire [PAGE_BITS-1:0]  key,
  input  wire                  is_last,
  input  wire                  load,
  input  wire                  fill,
  input  wire                  tok_in,
  output logic                 pass_fwd,
  output logic                 pass_wrap,
  output logic                 stop,
  output logic                 out_valid,
  output logic [PAGE_BITS-1:0] out_page
);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic                 referenced;
  logic                 tok;
  logic                 cond;
  logic                 pass;
  logic                 write;

  // In a hit search the token stops on a matching page; in a victim search
  // it stops on a clear reference bit.
  assign cond = scan.clock_mode ? !referenced : (valid && (page == key));
  assign stop = tok && scan.run && cond;
  assign pass = tok && scan.run && !cond;

  // A hit search ends at the last active slot; a victim search wraps.
  assign pass_fwd  = pass && !is_last;
  assign pass_wrap = pass && is_last && scan.clock_mode;

  assign write = fill || (stop && scan.clock_mode);

  assign out_valid = stop && valid;
  assign out_page  = stop ? page : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok        <= 1'b0;
      valid      <= 1'b0;
      referenced <= 1'b0;
    end else begin
      tok <= load || (scan.run && tok_in);
      if (write) begin
        valid <= 1'b1;
      end
      if (write || stop) begin
        referenced <= 1'b1;
      end else if (pass && scan.clock_mode) begin
        referenced <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write) begin
      page <= key;
    end
  end

endmodule : scr_cell
`default_nettype wire

>>> hw/rtl/scr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scan controller
// Sequences hit and victim searches, tracks the hand, fill and counters.
// ----------------------------------------------------------------------------
module scr_ctrl #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int IDX_W      = 4,
  parameter int LIM_W      = 5
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire [4:0]            frames_in_use,
  input  scr_pkg::status_t     status,
  input  wire [PAGE_BITS-1:0]  ev_page,
  output scr_pkg::scan_t       scan,
  output logic [IDX_W-1:0]     last,
  output logic                 load_en,
  output logic [IDX_W-1:0]     load_pos,
  output logic                 fill_en,
  output logic [IDX_W-1:0]     fill_pos,
  output logic                 busy,
  output logic                 done,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [3:0]           slot_index,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total
);

  scr_pkg::state_t state, state_next;

  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] filled;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] hand;
  logic [IDX_W-1:0] start_hand;
  logic [IDX_W-1:0] pos_wrap;
  logic [31:0]      hit_counter;
  logic [31:0]      miss_counter;
  logic             at_last;
  logic             has_free;
  logic             hit_found;
  logic             miss_end;
  logic             clock_found;
  logic             result_evt;

  always_comb begin
    if (frames_in_use == 5'd0) begin
      lim = LIM_W'(1);
    end else if (32'(frames_in_use) > 32'(NUM_FRAMES)) begin
      lim = LIM_W'(NUM_FRAMES);
    end else begin
      lim = LIM_W'(frames_in_use);
    end
  end

  assign last       = IDX_W'(lim - LIM_W'(1));
  assign at_last    = (pos == last);
  assign pos_wrap   = at_last ? '0 : pos + IDX_W'(1);
  assign has_free   = (filled < lim);
  assign start_hand = (LIM_W'(hand) < lim) ? hand : '0;
  assign fill_pos   = IDX_W'(filled);

  assign hit_found   = (state == scr_pkg::ST_HIT) && status.stop;
  assign miss_end    = (state == scr_pkg::ST_HIT) && !status.stop && at_last;
  assign clock_found = (state == scr_pkg::ST_CLOCK) && status.stop;
  assign result_evt  = hit_found || (miss_end && has_free) || clock_found;

  always_comb begin
    state_next = state;
    unique case (state)
      scr_pkg::ST_IDLE: begin
        if (start) begin
          state_next = scr_pkg::ST_HIT;
        end
      end
      scr_pkg::ST_HIT: begin
        if (status.stop) begin
          state_next = scr_pkg::ST_IDLE;
        end else if (at_last) begin
          state_next = has_free ? scr_pkg::ST_IDLE : scr_pkg::ST_CLOCK;
        end
      end
      scr_pkg::ST_CLOCK: begin
        if (status.stop) begin
          state_next = scr_pkg::ST_IDLE;
        end
      end
      default: state_next = scr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    scan.run        = 1'b0;
    scan.clock_mode = 1'b0;
    busy            = 1'b1;
    load_en         = 1'b0;
    load_pos        = '0;
    fill_en         = 1'b0;
    unique case (state)
      scr_pkg::ST_IDLE: begin
        busy    = 1'b0;
        load_en = start;
      end
      scr_pkg::ST_HIT: begin
        scan.run = 1'b1;
        load_en  = miss_end && !has_free;
        load_pos = start_hand;
        fill_en  = miss_end && has_free;
      end
      scr_pkg::ST_CLOCK: begin
        scan.run        = 1'b1;
        scan.clock_mode = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= scr_pkg::ST_IDLE;
      pos          <= '0;
      hand         <= '0;
      filled       <= '0;
      hit_counter  <= '0;
      miss_counter <= '0;
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= result_evt;
      if (state == scr_pkg::ST_IDLE) begin
        pos <= '0;
      end else if (miss_end) begin
        pos <= start_hand;
      end else if (!status.stop) begin
        pos <= pos_wrap;
      end
      if (clock_found) begin
        hand <= pos_wrap;
      end
      if (fill_en) begin
        filled <= filled + LIM_W'(1);
      end
      if (hit_found && (hit_counter != '1)) begin
        hit_counter <= hit_counter + 32'd1;
      end
      if (miss_end && (miss_counter != '1)) begin
        miss_counter <= miss_counter + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_evt) begin
      hit           <= hit_found;
      evicted_valid <= clock_found && status.ev_valid;
      evicted_page  <= clock_found ? ev_page : '0;
      slot_index    <= (miss_end && has_free) ? 4'(fill_pos) : 4'(pos);
    end
  end

  assign hit_total  = hit_counter;
  assign miss_total = miss_counter;

endmodule : scr_ctrl
`default_nettype wire

>>> hw/rtl/second_chance_page_replacement_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Second-chance page replacement core
// Clock replacement over a row of frame slot cells with a moving scan token.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------------
//   input     start high, busy low    page_number
//   result    done (one cycle)        hit, evicted_valid, evicted_page,
//                                     slot_index, hit_total, miss_total
//   config    cfg_we                  cfg_wdata (frames_in_use)
//
// Each item is handled by a token that walks the slot cells one slot per
// cycle. A hit search stops at the matching slot; a miss takes one pass over
// the L active slots, plus a clock-hand search when every slot is full. The
// result strobe follows in the cycle after the last step, in a cycle where
// busy is already low, so the next item may start there.
// Reset is synchronous and clears all slots, the hand, the fill count and
// both totals; frames_in_use returns to 16. The receiver cannot stall.
//
module second_chance_page_replacement_core #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire [PAGE_BITS-1:0]  page_number,
  output logic                 busy,
  input  wire                  cfg_we,
  input  wire [4:0]            cfg_wdata,
  output logic                 done,
  output logic                 hit,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page,
  output logic [3:0]           slot_index,
  output logic [31:0]          hit_total,
  output logic [31:0]          miss_total
);

  localparam int IDX_W = $clog2(NUM_FRAMES);
  localparam int LIM_W = $clog2(NUM_FRAMES + 1);

  // The frame limit register; the user must write it only while the core is idle, which the core does not enforce.
  logic [4:0] frames_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 5'd16;
    end else if (cfg_we) begin
      frames_in_use <= cfg_wdata;
    end
  end

  // The referenced page is held for the whole item and broadcast to all
  // cells as the compare and write key.
  logic [PAGE_BITS-1:0] key;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key <= page_number;
    end
  end

  scr_pkg::scan_t   scan;
  scr_pkg::status_t status;
  logic [IDX_W-1:0] last;
  logic             load_en;
  logic [IDX_W-1:0] load_pos;
  logic             fill_en;
  logic [IDX_W-1:0] fill_pos;

  logic [NUM_FRAMES-1:0] tok_in;
  logic [NUM_FRAMES-1:0] pass_fwd;
  logic [NUM_FRAMES-1:0] pass_wrap;
  logic [NUM_FRAMES-1:0] cell_stop;
  logic [NUM_FRAMES-1:0] cell_valid;
  logic [PAGE_BITS-1:0]  cell_page [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  ev_page;

  // Token ring: each cell feeds the next one, and the last active cell
  // feeds slot 0 during a victim search.
  always_comb begin
    tok_in[0] = |pass_wrap;
    for (int i = 1; i < NUM_FRAMES; i++) begin
      tok_in[i] = pass_fwd[i-1];
    end
  end

  // At most one cell holds the token, so its page can be merged with an OR.
  always_comb begin
    ev_page = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      ev_page = ev_page | cell_page[i];
    end
  end

  assign status.stop     = |cell_stop;
  assign status.ev_valid = |cell_valid;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    scr_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .scan      (scan),
      .key       (key),
      .is_last   (last == IDX_W'(g)),
      .load      (load_en && (load_pos == IDX_W'(g))),
      .fill      (fill_en && (fill_pos == IDX_W'(g))),
      .tok_in    (tok_in[g]),
      .pass_fwd  (pass_fwd[g]),
      .pass_wrap (pass_wrap[g]),
      .stop      (cell_stop[g]),
      .out_valid (cell_valid[g]),
      .out_page  (cell_page[g])
    );
  end

  scr_ctrl #(
    .NUM_FRAMES (NUM_FRAMES),
    .PAGE_BITS  (PAGE_BITS),
    .IDX_W      (IDX_W),
    .LIM_W      (LIM_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .frames_in_use (frames_in_use),
    .status        (status),
    .ev_page       (ev_page),
    .scan          (scan),
    .last          (last),
    .load_en       (load_en),
    .load_pos      (load_pos),
    .fill_en       (fill_en),
    .fill_pos      (fill_pos),
    .busy          (busy),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .slot_index    (slot_index),
    .hit_total     (hit_total),
    .miss_total    (miss_total)
  );

endmodule : second_chance_page_replacement_core
`default_nettype wire

>>> hw/rtl/scr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Checks the item and result sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module scr_checker #(
  parameter int PAGE_BITS = 16
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 start,
  input wire                 busy,
  input wire                 done,
  input wire                 hit,
  input wire                 evicted_valid,
  input wire [PAGE_BITS-1:0] evicted_page
);

  // A result is only reported once the item has finished.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // An accepted item always makes the core busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // A hit never replaces a page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> !evicted_valid)
    else $error("eviction reported on a hit");

  // No eviction means the evicted page reads as zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page nonzero without eviction");

endmodule : scr_checker

bind second_chance_page_replacement_core scr_checker #(
  .PAGE_BITS (PAGE_BITS)
) u_scr_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .hit           (hit),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page)
);
`default_nettype wire

>>> test/tb_second_chance_page_replacement_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Second-chance page replacement core testbench
// Sends page references through the start/busy handshake and predicts each
// result with a clock-replacement model of the frame slots. Every done strobe
// is compared field by field with the oldest prediction. The frame count is
// changed between phases while the core is idle.
// ----------------------------------------------------------------------------
module tb_second_chance_page_replacement_core;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;
  // The longest item is a miss over 16 full slots: one pass, a clock-hand
  // search, and the result strobe.
  localparam int DRAIN_CYCLES = 40;

  // One expected result of the core.
  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [15:0] evicted_page;
    logic [3:0]  slot_index;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } frame_outcome_t;

  // Clock-replacement model of the frame slots together with the queue of
  // results that the core still owes.
  class clock_frames;
    logic [15:0]    page_of [SLOTS];
    bit             held    [SLOTS];
    bit             recent  [SLOTS];
    int unsigned    filled;
    int unsigned    hand;
    bit [31:0]      hits;
    bit [31:0]      misses;
    bit [4:0]       frames_cfg;
    frame_outcome_t owed_outcomes[$];
    int unsigned    mismatches;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        page_of[i] = '0;
        held[i]    = 1'b0;
        recent[i]  = 1'b0;
      end
      filled     = 0;
      hand       = 0;
      hits       = '0;
      misses     = '0;
      frames_cfg = 5'd16;
      mismatches = 0;
    endfunction

    function void set_frames(logic [4:0] value);
      frames_cfg = value;
    endfunction

    function int unsigned pending();
      return owed_outcomes.size();
    endfunction

    // Works out the result of one accepted page reference.
    function void note_request(logic [15:0] pg);
      frame_outcome_t r;
      int unsigned    lim;
      int unsigned    s;
      int unsigned    h;
      int unsigned    n;
      int unsigned    i;
      bit             found;
      // A zero setting still keeps one slot; anything past the slot count
      // is clipped to it.
      if (frames_cfg == 0) lim = 1;
      else if (frames_cfg > SLOTS) lim = SLOTS;
      else lim = frames_cfg;
      r     = '0;
      s     = 0;
      found = 1'b0;
      for (i = 0; i < lim; i++) begin
        if (!found && held[i] && page_of[i] == pg) begin
          s     = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.hit     = 1'b1;
        recent[s] = 1'b1;
        if (hits != '1) hits++;
      end else begin
        if (misses != '1) misses++;
        if (filled < lim) begin
          s = filled;
          filled++;
        end else begin
          // The hand may sit past a shrunk frame set; it starts over at 0.
          h = (hand < lim) ? hand : 0;
          n = 0;
          while (n <= lim && recent[h]) begin
            recent[h] = 1'b0;
            h = (h + 1 < lim) ? h + 1 : 0;
            n++;
          end
          s = h;
          if (held[s]) begin
            r.evicted_valid = 1'b1;
            r.evicted_page  = page_of[s];
          end
          hand = (h + 1 < lim) ? h + 1 : 0;
        end
        page_of[s] = pg;
        held[s]    = 1'b1;
        recent[s]  = 1'b1;
      end
      r.slot_index = 4'(s);
      r.hit_total  = hits;
      r.miss_total = misses;
      owed_outcomes = {owed_outcomes, r};
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_outcome(frame_outcome_t got);
      frame_outcome_t want;
      if (owed_outcomes.size() == 0) begin
        report_mismatch("result strobe with no reference outstanding");
        return;
      end
      want = owed_outcomes.pop_front();
      if (got.hit !== want.hit)
        report_mismatch($sformatf("hit %0b, want %0b", got.hit, want.hit));
      if (got.evicted_valid !== want.evicted_valid)
        report_mismatch($sformatf("evicted_valid %0b, want %0b",
                                  got.evicted_valid, want.evicted_valid));
      if (got.evicted_page !== want.evicted_page)
        report_mismatch($sformatf("evicted_page %h, want %h",
                                  got.evicted_page, want.evicted_page));
      if (got.slot_index !== want.slot_index)
        report_mismatch($sformatf("slot_index %0d, want %0d",
                                  got.slot_index, want.slot_index));
      if (got.hit_total !== want.hit_total)
        report_mismatch($sformatf("hit_total %0d, want %0d",
                                  got.hit_total, want.hit_total));
      if (got.miss_total !== want.miss_total)
        report_mismatch($sformatf("miss_total %0d, want %0d",
                                  got.miss_total, want.miss_total));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic [15:0] page_number;
  logic        busy;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        done;
  logic        hit;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [3:0]  slot_index;
  logic [31:0] hit_total;
  logic [31:0] miss_total;

  clock_frames    frames;
  frame_outcome_t seen;
  int unsigned    cycles;

  second_chance_page_replacement_core DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .page_number   (page_number),
    .busy          (busy),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .hit           (hit),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .slot_index    (slot_index),
    .hit_total     (hit_total),
    .miss_total    (miss_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The run is cut off here if the core stops answering.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("second_chance_page_replacement_core test failed");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is checked in the cycle it
  // appears. Outputs are sampled at the edge, before the core updates them.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      seen.hit           = hit;
      seen.evicted_valid = evicted_valid;
      seen.evicted_page  = evicted_page;
      seen.slot_index    = slot_index;
      seen.hit_total     = hit_total;
      seen.miss_total    = miss_total;
      frames.check_outcome(seen);
    end
  end

  // Presents one page reference and returns at the edge that takes it. With
  // a gap, start drops and the gap is waited out while the core works on the
  // item; without one, start stays high so the next item follows right away.
  task automatic send_page(input logic [15:0] pg, input int unsigned gap);
    start       <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (busy) @(posedge clk);
    frames.note_request(pg);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Changes the frame count once every outstanding result has come back.
  // Every item ends in a result, so an empty queue means the core is idle.
  task automatic write_frames(input logic [4:0] value);
    start <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames.set_frames(value);
  endtask

  // Directed references: page extremes, fills, hits, evictions with every
  // bit set, the single-slot case, a zero and an oversized frame count, and
  // a shrink that leaves some pages outside the active set.
  task automatic run_directed();
    write_frames(5'd2);
    send_page(16'h0000, 0);
    send_page(16'hFFFF, 0);
    send_page(16'h0000, 2);
    send_page(16'hFFFF, 0);
    send_page(16'h1234, 0);
    send_page(16'hFFFF, 3);
    send_page(16'h5555, 0);
    write_frames(5'd0);
    send_page(16'h00FF, 0);
    send_page(16'hFF00, 1);
    send_page(16'hFF00, 0);
    send_page(16'h8000, 0);
    write_frames(5'd31);
    send_page(16'h0001, 0);
    send_page(16'h0002, 0);
    send_page(16'h1234, 0);
    send_page(16'h7FFF, 4);
    send_page(16'hFFFF, 0);
    write_frames(5'd3);
    send_page(16'hAAAA, 0);
    send_page(16'h5555, 0);
    send_page(16'h0001, 0);
    send_page(16'h8000, 0);
  endtask

  // One phase of random references at a given frame count. Most pages come
  // from a small working set sized a little past the active slots, so hits,
  // fills and clock-hand evictions all occur; the rest are arbitrary pages.
  task automatic run_phase(input logic [4:0] value, input int unsigned count,
                           input bit idle_on);
    logic [15:0] pool [0:19];
    int unsigned pool_size;
    int unsigned lim;
    int unsigned gap;
    logic [15:0] pg;
    bit          calm;
    write_frames(value);
    if (value == 0) lim = 1;
    else if (value > SLOTS) lim = SLOTS;
    else lim = value;
    pool_size = lim + $urandom_range(1, 4);
    for (int i = 0; i < 20; i++) pool[i] = 16'($urandom());
    calm = 1'b0;
    for (int k = 0; k < count; k++) begin
      // Idling comes and goes in stretches of sixteen items.
      if (k % 16 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 4) pool[$urandom_range(0, pool_size - 1)] = 16'($urandom());
      if ($urandom_range(0, 99) < 78) pg = pool[$urandom_range(0, pool_size - 1)];
      else pg = 16'($urandom());
      gap = 0;
      if (idle_on && !calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
      send_page(pg, gap);
    end
  endtask

  initial begin
    frames      = new();
    cycles      <= 0;
    rst         <= 1'b1;
    start       <= 1'b0;
    page_number <= '0;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();

    // Frame counts run through the extremes and back, so later phases start
    // with the hand beyond the set or with pages parked above the limit.
    run_phase(5'd16, 77, 1'b1);
    run_phase(5'd4,  77, 1'b1);
    run_phase(5'd31, 77, 1'b1);
    run_phase(5'd1,  77, 1'b1);
    run_phase(5'd17, 77, 1'b1);
    run_phase(5'd0,  77, 1'b1);
    run_phase(5'd8,  77, 1'b1);
    run_phase(5'd2,  77, 1'b1);
    run_phase(5'd16, 77, 1'b1);
    run_phase(5'd12, 77, 1'b1);
    // The closing phases send back to back.
    run_phase(5'($urandom_range(0, 31)), 77, 1'b0);
    run_phase(5'($urandom_range(0, 31)), 77, 1'b0);

    start <= 1'b0;
    while (frames.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frames.mismatches == 0 && frames.pending() == 0) begin
      $display("second_chance_page_replacement_core test passed");
    end else begin
      $display("second_chance_page_replacement_core test failed");
    end
    $finish;
  end

endmodule
